/* src/button_debounce_autorepeat_macros.svh */
// Assertion macros for the button debounce block.
// Used by the top level only; no other dependencies.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BDA_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bda assertion failed");

// Next-cycle implication, disabled during reset
`define BDA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("bda assertion failed");

`endif

/* src/bda_pkg.sv */
// Shared types, constants and helpers for the button debounce block.
// No dependencies.
package bda_pkg;

  localparam int MASK_W      = 8;
  localparam int CODE_W      = 3;
  localparam int TIME_W      = 32;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int DEB_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SAMPLES = 2'd2;

  // Register reset values and limits
  localparam logic [CFG_DATA_W-1:0] REPEAT_INTERVAL_RST = 16'd200;
  localparam logic [CFG_DATA_W-1:0] REPEAT_INTERVAL_MIN = 16'd50;
  localparam logic [CFG_DATA_W-1:0] HOLD_TIME_RST       = 16'd650;
  localparam logic [DEB_W-1:0]      DEBOUNCE_RST        = 4'd3;

  // Action codes
  localparam logic [CODE_W-1:0] CODE_ACTION  = 3'd4;
  localparam logic [CODE_W-1:0] CODE_RESTART = 3'd7;

  // What the front end saw on one poll
  typedef enum logic [2:0] {
    EV_TICK,     // mask not stable yet: repeat check only
    EV_SAME,     // stable and unchanged: repeat, then hold check
    EV_PRESS,    // stable mask went from empty to pressed
    EV_RELEASE,  // stable mask went to empty
    EV_CHANGE    // stable mask changed while held
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t                kind;
    logic [CODE_W-1:0]       code;
    logic [TIME_W-1:0]       now_time;
  } ev_entry_t;

  typedef struct packed {
    logic                    we;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]   data;
  } cfg_wr_t;

  typedef struct packed {
    logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
    logic                             full;
    logic                             valid;
  } q_stat_t;

  // Lowest set bit as an action code; empty mask gives the action code
  function automatic logic [CODE_W-1:0] lowest_code(input logic [MASK_W-1:0] mask);
    logic [CODE_W-1:0] code;
    logic              found;
    code  = CODE_ACTION;
    found = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (mask[i] && !found) begin
        code  = CODE_W'(i);
        found = 1'b1;
      end
    end
    return code;
  endfunction

endpackage

/* src/bda_ifs.sv */
// Valid/ready channel interfaces for poll samples and action results.
// Depends on bda_pkg for field widths.
interface bda_in_if;
  logic                         valid;
  logic                         ready;
  logic [bda_pkg::MASK_W-1:0]   pin_levels;
  logic                         read_ok;
  logic [bda_pkg::TIME_W-1:0]   now_time;

  modport source (output valid, pin_levels, read_ok, now_time, input ready);
  modport sink   (input valid, pin_levels, read_ok, now_time, output ready);
endinterface

interface bda_out_if;
  logic                         valid;
  logic                         ready;
  logic [bda_pkg::CODE_W-1:0]   action_code;

  modport source (output valid, action_code, input ready);
  modport sink   (input valid, action_code, output ready);
endinterface

/* src/button_debounce_autorepeat.sv */
// Button debounce with auto-repeat and long press.
// An action from a poll passes through the event queue and the output register before it is offered.
// Throughput: one poll per cycle while the queue is not full; the back end applies
// one queued event per cycle and stalls only while its output register waits.
// Reset (rst, synchronous): clears masks, timers and queue; registers return
// to repeat 200 ms, hold 650 ms, 3 debounce samples.
module button_debounce_autorepeat #(
  parameter int BUTTON_COUNT = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bda_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bda_pkg::CFG_DATA_W-1:0]     cfg_data,
  bda_in_if.sink                             in_ch,
  bda_out_if.source                          out_ch
);

  `include "button_debounce_autorepeat_macros.svh"

  bda_pkg::cfg_wr_t   cfg;
  bda_pkg::ev_entry_t front_entry;
  bda_pkg::ev_entry_t head;
  bda_pkg::q_stat_t   q_stat;
  logic               in_accept;
  logic               pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_ch.ready = !q_stat.full;
  assign in_accept   = in_ch.valid && in_ch.ready;

  bda_front #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (in_accept),
    .pin_levels (in_ch.pin_levels),
    .read_ok    (in_ch.read_ok),
    .now_time   (in_ch.now_time),
    .entry      (front_entry)
  );

  bda_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_accept),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  bda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ev_valid  (q_stat.valid),
    .ev        (head),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_code  (out_ch.action_code)
  );

  // Queue never holds more than its depth
  `BDA_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1,
                  q_stat.count <= ($clog2(bda_pkg::QUEUE_DEPTH + 1))'(bda_pkg::QUEUE_DEPTH))
  // A poll taken into an empty queue is waiting in it on the next cycle
  `BDA_ASSERT_NEXT(a_push_lands, clk, rst, in_accept && !q_stat.valid, q_stat.valid)
  // No action appears without a queued event behind it
  `BDA_ASSERT_NEXT(a_no_phantom, clk, rst, !q_stat.valid && !out_ch.valid, !out_ch.valid)

endmodule

/* src/bda_front.sv */
// Front end: debounces each poll sample and classifies the stable mask change.
// Depends on bda_pkg.
module bda_front #(
  parameter int BUTTON_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bda_pkg::cfg_wr_t             cfg,
  input  logic                         accept,
  input  logic [bda_pkg::MASK_W-1:0]   pin_levels,
  input  logic                         read_ok,
  input  logic [bda_pkg::TIME_W-1:0]   now_time,
  output bda_pkg::ev_entry_t           entry
);

  localparam logic [bda_pkg::MASK_W-1:0] BUTTON_MASK =
    bda_pkg::MASK_W'((9'd1 << BUTTON_COUNT) - 9'd1);

  logic [bda_pkg::DEB_W-1:0]  debounce_samples;
  logic [bda_pkg::MASK_W-1:0] last_sample;
  logic [bda_pkg::DEB_W-1:0]  stable_count;
  logic [bda_pkg::MASK_W-1:0] stable_buttons;

  logic [bda_pkg::MASK_W-1:0] raw;
  logic [bda_pkg::DEB_W-1:0]  stable_count_next;
  logic                       is_stable;

  // Pick the sample and advance the run counter
  always_comb begin
    raw = read_ok ? (~pin_levels & BUTTON_MASK) : stable_buttons;
    if (raw == last_sample) begin
      stable_count_next = (stable_count < debounce_samples) ?
                          stable_count + 1'b1 : stable_count;
    end else begin
      stable_count_next = '0;
    end
    is_stable = !(stable_count_next < debounce_samples);
  end

  // Classify against the previous stable mask
  always_comb begin
    entry.now_time = now_time;
    entry.code     = bda_pkg::lowest_code(raw);
    if (!is_stable) begin
      entry.kind = bda_pkg::EV_TICK;
    end else if (raw == stable_buttons) begin
      entry.kind = bda_pkg::EV_SAME;
    end else if (stable_buttons == '0) begin
      entry.kind = bda_pkg::EV_PRESS;
    end else if (raw == '0) begin
      entry.kind = bda_pkg::EV_RELEASE;
    end else begin
      entry.kind = bda_pkg::EV_CHANGE;
    end
  end

  // Hold debounce state and the sample count register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_samples <= bda_pkg::DEBOUNCE_RST;
      last_sample      <= '0;
      stable_count     <= '0;
      stable_buttons   <= '0;
    end else begin
      if (cfg.we && cfg.index == bda_pkg::REG_DEBOUNCE_SAMPLES) begin
        debounce_samples <= cfg.data[bda_pkg::DEB_W-1:0];
      end
      if (accept) begin
        last_sample  <= raw;
        stable_count <= stable_count_next;
        if (is_stable) begin
          stable_buttons <= raw;
        end
      end
    end
  end

endmodule

/* src/bda_queue.sv */
// Short FIFO of classified events between the front and back ends.
// Depends on bda_pkg.
module bda_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bda_pkg::ev_entry_t  push_entry,
  input  logic                pop,
  output bda_pkg::ev_entry_t  head,
  output bda_pkg::q_stat_t    stat
);

  localparam int DEPTH = bda_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bda_pkg::ev_entry_t slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head       = slots[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.valid = (count != '0);

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/bda_back.sv */
// Back end: repeat and long-press timers, action emission, output register.
// Depends on bda_pkg.
module bda_back (
  input  logic                        clk,
  input  logic                        rst,
  input  bda_pkg::cfg_wr_t            cfg,
  input  logic                        ev_valid,
  input  bda_pkg::ev_entry_t          ev,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bda_pkg::CODE_W-1:0]  out_code
);

  logic [bda_pkg::CFG_DATA_W-1:0] repeat_interval;
  logic [bda_pkg::CFG_DATA_W-1:0] hold_time;

  logic                          repeating,        repeating_next;
  logic                          restart_holding,  restart_holding_next;
  logic                          restart_done,     restart_done_next;
  logic [bda_pkg::CODE_W-1:0]    held_code,        held_code_next;
  logic [bda_pkg::TIME_W-1:0]    last_repeat_time, last_repeat_time_next;
  logic [bda_pkg::TIME_W-1:0]    hold_start_time,  hold_start_time_next;

  logic                          fire;
  logic [bda_pkg::CODE_W-1:0]    fire_code;
  logic [bda_pkg::TIME_W-1:0]    repeat_age;
  logic [bda_pkg::TIME_W-1:0]    hold_age;
  logic                          repeat_due;
  logic                          hold_due;

  assign pop = ev_valid && (!out_valid || out_ready);

  // Timer checks against the current state
  always_comb begin
    repeat_age = ev.now_time - last_repeat_time;
    hold_age   = ev.now_time - hold_start_time;
    repeat_due = repeating &&
                 !(repeat_age < bda_pkg::TIME_W'(repeat_interval));
    hold_due   = restart_holding && !restart_done &&
                 !(hold_age < bda_pkg::TIME_W'(hold_time));
  end

  // Apply one event to the timer state
  always_comb begin
    repeating_next        = repeating;
    restart_holding_next  = restart_holding;
    restart_done_next     = restart_done;
    held_code_next        = held_code;
    last_repeat_time_next = last_repeat_time;
    hold_start_time_next  = hold_start_time;
    fire                  = 1'b0;
    fire_code             = held_code;
    case (ev.kind)
      bda_pkg::EV_TICK: begin
        if (repeat_due) begin
          fire                  = 1'b1;
          fire_code             = held_code;
          last_repeat_time_next = ev.now_time;
        end
      end
      bda_pkg::EV_SAME: begin
        if (repeat_due) begin
          fire                  = 1'b1;
          fire_code             = held_code;
          last_repeat_time_next = ev.now_time;
        end else if (hold_due) begin
          fire              = 1'b1;
          fire_code         = bda_pkg::CODE_RESTART;
          restart_done_next = 1'b1;
        end
      end
      bda_pkg::EV_PRESS: begin
        if (ev.code == bda_pkg::CODE_RESTART) begin
          restart_holding_next = 1'b1;
          restart_done_next    = 1'b0;
          hold_start_time_next = ev.now_time;
          held_code_next       = bda_pkg::CODE_RESTART;
          repeating_next       = 1'b0;
        end else begin
          restart_holding_next = 1'b0;
          restart_done_next    = 1'b0;
          fire                 = 1'b1;
          fire_code            = ev.code;
          if (ev.code < bda_pkg::CODE_ACTION) begin
            repeating_next        = 1'b1;
            held_code_next        = ev.code;
            last_repeat_time_next = ev.now_time;
          end else begin
            repeating_next = 1'b0;
          end
        end
      end
      bda_pkg::EV_RELEASE: begin
        repeating_next       = 1'b0;
        restart_holding_next = 1'b0;
        restart_done_next    = 1'b0;
      end
      bda_pkg::EV_CHANGE: begin
        held_code_next = ev.code;
        if (ev.code == bda_pkg::CODE_RESTART) begin
          // Hold restarts now, so it is due at once only for a zero hold time
          restart_holding_next = 1'b1;
          hold_start_time_next = ev.now_time;
          repeating_next       = 1'b0;
          fire                 = (hold_time == '0);
          fire_code            = bda_pkg::CODE_RESTART;
          restart_done_next    = (hold_time == '0);
        end else begin
          restart_holding_next  = 1'b0;
          restart_done_next     = 1'b0;
          fire                  = 1'b1;
          fire_code             = ev.code;
          repeating_next        = (ev.code < bda_pkg::CODE_ACTION);
          last_repeat_time_next = ev.now_time;
        end
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  // Hold timer state, configuration and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_interval  <= bda_pkg::REPEAT_INTERVAL_RST;
      hold_time        <= bda_pkg::HOLD_TIME_RST;
      repeating        <= 1'b0;
      restart_holding  <= 1'b0;
      restart_done     <= 1'b0;
      held_code        <= '0;
      last_repeat_time <= '0;
      hold_start_time  <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.we && cfg.index == bda_pkg::REG_REPEAT_INTERVAL) begin
        repeat_interval <= (cfg.data < bda_pkg::REPEAT_INTERVAL_MIN) ?
                           bda_pkg::REPEAT_INTERVAL_MIN : cfg.data;
      end
      if (cfg.we && cfg.index == bda_pkg::REG_HOLD_TIME) begin
        hold_time <= cfg.data;
      end
      if (pop) begin
        repeating        <= repeating_next;
        restart_holding  <= restart_holding_next;
        restart_done     <= restart_done_next;
        held_code        <= held_code_next;
        last_repeat_time <= last_repeat_time_next;
        hold_start_time  <= hold_start_time_next;
        out_valid        <= fire;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop && fire) begin
      out_code <= fire_code;
    end
  end

endmodule

/* test/tb_button_debounce_autorepeat.sv */
// Self-checking testbench for button_debounce_autorepeat: drives poll samples and
// register writes, predicts each action code and compares it with the output channel.
// Depends on bda_pkg, the bda_in_if / bda_out_if channels and the block itself.
`timescale 1ns / 1ps

module tb_button_debounce_autorepeat;

  localparam int  LIMIT_NS     = 3_000_000;
  localparam int  DRAIN_CYCLES = 12;
  localparam int  SQUEEZE_CYC  = 120;
  localparam int  MAX_IDLE     = 17;

  // Predicts the action codes of the block and checks what comes out
  class action_scoreboard;
    logic [15:0] repeat_ms = bda_pkg::REPEAT_INTERVAL_RST;
    logic [15:0] hold_ms   = bda_pkg::HOLD_TIME_RST;
    logic [3:0]  deb_need  = bda_pkg::DEBOUNCE_RST;

    logic [7:0]  prev_sample     = '0;
    logic [3:0]  same_count      = '0;
    logic [7:0]  stable_mask     = '0;
    bit          repeating       = 1'b0;
    bit          holding_restart = 1'b0;
    bit          restart_fired   = 1'b0;
    logic [2:0]  held_code       = '0;
    logic [31:0] last_repeat_ms  = '0;
    logic [31:0] hold_start_ms   = '0;

    logic [2:0]  due_actions[$];
    int          errors = 0;

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        bda_pkg::REG_REPEAT_INTERVAL:
          repeat_ms = (data < bda_pkg::REPEAT_INTERVAL_MIN) ?
                      bda_pkg::REPEAT_INTERVAL_MIN : data;
        bda_pkg::REG_HOLD_TIME:        hold_ms = data;
        bda_pkg::REG_DEBOUNCE_SAMPLES: deb_need = data[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_actions.size();
    endfunction

    // Append one predicted action at the tail
    function void add_due(logic [2:0] code);
      due_actions = {due_actions, code};
    endfunction

    // Lowest pressed button; an empty mask maps to the action code
    function logic [2:0] first_pressed(logic [7:0] mask);
      for (int i = 0; i < 8; i++)
        if (mask[i]) return 3'(i);
      return bda_pkg::CODE_ACTION;
    endfunction

    function bit repeat_due(logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - last_repeat_ms;
      if (!repeating || elapsed < {16'd0, repeat_ms}) return 1'b0;
      add_due(held_code);
      last_repeat_ms = now;
      return 1'b1;
    endfunction

    function bit hold_due(logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - hold_start_ms;
      if (!holding_restart || restart_fired || elapsed < {16'd0, hold_ms}) return 1'b0;
      add_due(bda_pkg::CODE_RESTART);
      restart_fired = 1'b1;
      return 1'b1;
    endfunction

    function void begin_restart(logic [31:0] now);
      holding_restart = 1'b1;
      restart_fired   = 1'b0;
      hold_start_ms   = now;
      held_code       = bda_pkg::CODE_RESTART;
      repeating       = 1'b0;
    endfunction

    // Advance the prediction by one accepted poll transaction
    function void note_poll(logic [7:0] pins, logic ok, logic [31:0] now);
      logic [7:0] raw;
      logic [7:0] prev;
      logic [2:0] code;
      bit         fired;
      raw = ok ? ~pins : stable_mask;

      // debounce: count identical samples
      if (raw == prev_sample) begin
        if (same_count < deb_need) same_count++;
      end else begin
        prev_sample = raw;
        same_count  = '0;
      end
      if (same_count < deb_need) begin
        void'(repeat_due(now));
        return;
      end

      prev        = stable_mask;
      stable_mask = raw;
      if (raw == prev) begin
        if (!repeat_due(now)) void'(hold_due(now));
      end else if (prev == '0) begin
        // press from empty: restart only arms the hold
        code = first_pressed(raw);
        if (code == bda_pkg::CODE_RESTART) begin
          begin_restart(now);
        end else begin
          holding_restart = 1'b0;
          restart_fired   = 1'b0;
          add_due(code);
          repeating = code < bda_pkg::CODE_ACTION;
          if (repeating) begin
            held_code      = code;
            last_repeat_ms = now;
          end
        end
      end else if (raw == '0) begin
        repeating       = 1'b0;
        holding_restart = 1'b0;
        restart_fired   = 1'b0;
      end else begin
        // mask changed while held
        code      = first_pressed(raw);
        held_code = code;
        fired     = 1'b0;
        if (code == bda_pkg::CODE_RESTART) begin
          begin_restart(now);
        end else begin
          holding_restart = 1'b0;
          restart_fired   = 1'b0;
          add_due(code);
          fired          = 1'b1;
          repeating      = code < bda_pkg::CODE_ACTION;
          last_repeat_ms = now;
        end
        if (!fired && !repeat_due(now)) void'(hold_due(now));
      end
    endfunction

    task report(string what);
      $display("ERROR: %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_action(logic [2:0] got);
      logic [2:0] want;
      if (due_actions.size() == 0) begin
        report($sformatf("action %0d with none predicted", got));
      end else begin
        want = due_actions.pop_front();
        if (got !== want) report($sformatf("action_code %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bda_pkg::CFG_DATA_W-1:0] cfg_data;

  bda_in_if  in_ch ();
  bda_out_if out_ch ();

  button_debounce_autorepeat DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  action_scoreboard sb = new();

  logic [31:0] now_ms      = '0;
  int          polls_sent  = 0;
  int          send_burst  = 0;
  int          rx_burst    = 0;
  bit          squeeze_rx  = 1'b0;

  always #5 clk = ~clk;

  // Idle cycles before the next transaction, with stretches of none
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_IDLE);
  endfunction

  // Offer one poll; returns at the edge that accepts it
  task automatic send_poll(input logic [7:0] pins, input logic ok, input logic [31:0] stamp);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pin_levels <= pins;
    in_ch.read_ok    <= ok;
    in_ch.now_time   <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_poll(pins, ok, stamp);
    polls_sent++;
  endtask

  task automatic write_regs(input logic [15:0] interval, input logic [15:0] hold,
                            input logic [3:0] deb);
    cfg_we    <= 1'b1;
    cfg_index <= bda_pkg::REG_REPEAT_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_index <= bda_pkg::REG_HOLD_TIME;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_index <= bda_pkg::REG_DEBOUNCE_SAMPLES;
    cfg_data  <= {12'd0, deb};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(bda_pkg::REG_REPEAT_INTERVAL, interval);
    sb.set_reg(bda_pkg::REG_HOLD_TIME, hold);
    sb.set_reg(bda_pkg::REG_DEBOUNCE_SAMPLES, {12'd0, deb});
  endtask

  // Drop valid and wait until every predicted action has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hold one mask for n polls, with occasional bounce and failed reads
  task automatic hold_mask(input logic [7:0] mask, input int n, input int step_max);
    logic [7:0] pins;
    logic       ok;
    for (int k = 0; k < n; k++) begin
      pins = ~mask;
      ok   = 1'b1;
      case ($urandom_range(0, 19))
        0: pins = 8'($urandom);
        1: begin
          ok   = 1'b0;
          pins = 8'($urandom);
        end
        default: ;
      endcase
      now_ms = now_ms + $urandom_range(0, step_max);
      send_poll(pins, ok, now_ms);
    end
  endtask

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'h01 << $urandom_range(0, 7);
      4, 5:       return 8'h01 << bda_pkg::CODE_RESTART;
      6, 7, 8:    return 8'($urandom_range(1, 255));
      default:    return 8'hFF;
    endcase
  endfunction

  // Mostly press/hold/release sequences, some noise and time jumps
  task automatic run_phase(input int n_items, input bit squeeze);
    int         first;
    int         step_max;
    logic [7:0] mask;
    first    = polls_sent;
    step_max = ((sb.repeat_ms > sb.hold_ms) ? sb.repeat_ms : sb.hold_ms) / 3 + 20;

    // hold a direction with a repeat due every poll while the output stalls
    if (squeeze) begin
      squeeze_rx = 1'b1;
      send_burst = sb.deb_need + 40;
      mask = 8'h01 << $urandom_range(0, 3);
      for (int k = 0; k < sb.deb_need + 30; k++) begin
        now_ms = now_ms + sb.repeat_ms;
        send_poll(~mask, 1'b1, now_ms);
      end
      hold_mask(8'h00, sb.deb_need + 1, step_max);
    end

    while (polls_sent - first < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          mask = pick_mask();
          hold_mask(mask, sb.deb_need + $urandom_range(1, 10), step_max);
          if ($urandom_range(0, 2) != 0)
            hold_mask(8'h00, sb.deb_need + $urandom_range(1, 3), step_max);
        end
        7: begin
          repeat ($urandom_range(1, 5)) begin
            now_ms = now_ms + $urandom_range(0, step_max);
            send_poll(8'($urandom), 1'($urandom_range(0, 1)), now_ms);
          end
        end
        8:       now_ms = $urandom;
        default: now_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * step_max);
      endcase
    end
  endtask

  // Every code once, restart from empty and while held, failed read,
  // all pins low, time running backwards and across the wrap
  task automatic run_directed();
    send_poll(~8'h01, 1'b1, 32'd0);
    send_poll(~8'h01, 1'b1, 32'd10);
    send_poll(~8'h01, 1'b1, 32'd60);
    send_poll(~8'h02, 1'b1, 32'd70);
    send_poll(~8'h04, 1'b1, 32'd80);
    send_poll(~8'h08, 1'b1, 32'd90);
    send_poll(~8'h10, 1'b1, 32'd100);
    send_poll(~8'h20, 1'b1, 32'd110);
    send_poll(~8'h40, 1'b1, 32'd120);
    send_poll(~8'h80, 1'b1, 32'd130);
    send_poll(~8'h80, 1'b1, 32'd140);
    send_poll(8'hFF, 1'b1, 32'd150);
    send_poll(~8'h80, 1'b1, 32'd160);
    send_poll(~8'h80, 1'b1, 32'd160);
    send_poll(8'hFF, 1'b1, 32'd170);
    send_poll(8'h00, 1'b0, 32'd180);
    send_poll(8'h00, 1'b1, 32'd190);
    send_poll(8'h00, 1'b1, 32'd20);
    send_poll(8'h00, 1'b1, 32'hFFFF_FFFF);
    send_poll(8'h00, 1'b1, 32'd0);
    send_poll(8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_poll(~8'h60, 1'b1, 32'd5);
    send_poll(~8'h50, 1'b1, 32'd6);
    send_poll(8'hFF, 1'b1, 32'd7);
    now_ms = 32'd7;
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (squeeze_rx) begin
        stall      = SQUEEZE_CYC;
        squeeze_rx = 1'b0;
      end else begin
        stall = draw_gap(rx_burst);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_action(out_ch.action_code);
    end
  end

  // Stimulus
  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= bda_pkg::REG_REPEAT_INTERVAL;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.pin_levels <= 8'hFF;
    in_ch.read_ok    <= 1'b1;
    in_ch.now_time   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_phase(100, 1'b0);
    drain();

    // minimum interval by clamp, no hold, no debounce
    write_regs(16'd0, 16'd0, 4'd0);
    run_directed();
    drain();

    write_regs(16'hFFFF, 16'hFFFF, 4'd15);
    run_phase(100, 1'b1);
    drain();

    write_regs(bda_pkg::REPEAT_INTERVAL_MIN, 16'd1, 4'd1);
    run_phase(100, 1'b1);
    drain();

    write_regs(16'd49, 16'd300, 4'd2);
    run_phase(100, 1'b0);
    drain();

    write_regs(16'd0, 16'd0, 4'd0);
    run_phase(100, 1'b1);
    drain();

    repeat (2) begin
      write_regs(16'($urandom_range(50, 400)), 16'($urandom_range(1, 1000)),
                 4'($urandom_range(0, 4)));
      run_phase(100, 1'b1);
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #LIMIT_NS;
    $display("Mismatches found");
    $finish;
  end

endmodule
